FILE: rtl/core/gcna_pkg.sv
`default_nettype none
package gcna_pkg;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] surface_nx;
    logic signed [15:0] surface_ny;
    logic signed [15:0] surface_nz;
    logic [6:0]         cell_col;
    logic [6:0]         cell_row;
  } item_t;

  typedef struct packed {
    logic               cell_occupied;
    logic signed [15:0] mean_height;
    logic signed [15:0] unit_nx;
    logic signed [15:0] unit_ny;
    logic signed [15:0] unit_nz;
    logic [15:0]        point_total;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input item
    logic clr_step;   // write zero at the sweep address
    logic rd;         // read the cell at the captured address
    logic wr;         // write back accumulated sums
    logic div_start;  // launch the height divider
    logic nrm_start;  // launch the normal unit
    logic emit;       // present the result
  } ctl_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic clr_last;   // sweep at last cell
    logic on_grid;    // captured address lies on the grid
    logic div_done;
    logic nrm_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/grid_cell_normal_averager_top.sv
`default_nettype none
// Channel  | Ports                     | Transfer
// ---------+---------------------------+------------------------------
// command  | start, busy, item         | start high while busy low
// result   | strobe, result            | strobe high, one cycle, no stall
//
// Accumulate steps through read, modify and write states after the transfer; a
// point off the grid is dropped in the read state. Query: the height divide
// (64 steps, its own divider) runs beside the normal unit, which sets the time:
// normalize shifts, a 32-step square root and three 64-step divides; a zero
// normal sum skips the root and the divides. Clear and reset both sweep the
// store, one cell a cycle, all GRID_DIM*GRID_DIM cells, busy meanwhile. The
// receiver cannot stall; a result is shown for exactly one cycle.
module grid_cell_normal_averager_top #(
  parameter int unsigned GRID_DIM        = 100,
  parameter int unsigned CELLS_PER_METER = 50,
  parameter int unsigned COUNT_WIDTH     = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire gcna_pkg::item_t   item,
  output logic                   busy,
  output logic                   strobe,
  output gcna_pkg::result_t      result
);

  gcna_pkg::ctl_t ctl;
  gcna_pkg::sts_t sts;

  // Sequence each command.
  gcna_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(item.command),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  // Store, arithmetic and result register.
  gcna_dp #(
    .GridDim(GRID_DIM), .CellsPerMeter(CELLS_PER_METER), .CountWidth(COUNT_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(item), .sts(sts),
    .strobe(strobe), .result(result)
  );

endmodule
`default_nettype wire

FILE: rtl/core/gcna_ctrl.sv
`default_nettype none
module gcna_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     command,
  input  wire gcna_pkg::sts_t sts,
  output logic                busy,
  output gcna_pkg::ctl_t      ctl
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ARD   = 9'b000000100,
    S_AWR   = 9'b000001000,
    S_QRD   = 9'b000010000,
    S_QGO   = 9'b000100000,
    S_QWAIT = 9'b001000000,
    S_QOUT  = 9'b010000000,
    S_AMOD  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   dd, nd, dd_next, nd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      dd    <= 1'b0;
      nd    <= 1'b0;
    end else begin
      state <= state_next;
      dd    <= dd_next;
      nd    <= nd_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    dd_next    = dd | sts.div_done;
    nd_next    = nd | sts.nrm_done;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
        if (start) begin
          unique case (gcna_pkg::cmd_t'(command))
            gcna_pkg::CMD_ACCUM: state_next = S_ARD;
            gcna_pkg::CMD_QUERY: state_next = S_QRD;
            gcna_pkg::CMD_CLEAR: state_next = S_CLEAR;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_ARD: begin
        ctl.rd     = sts.on_grid;
        state_next = sts.on_grid ? S_AMOD : S_IDLE;
      end
      S_AMOD: state_next = S_AWR;
      S_AWR: begin
        ctl.wr     = 1'b1;
        state_next = S_IDLE;
      end
      S_QRD: begin
        ctl.rd     = 1'b1;
        state_next = S_QGO;
      end
      S_QGO: begin
        ctl.div_start = 1'b1;
        ctl.nrm_start = 1'b1;
        dd_next       = 1'b0;
        nd_next       = 1'b0;
        state_next    = S_QWAIT;
      end
      S_QWAIT: begin
        if (dd_next && nd_next) state_next = S_QOUT;
      end
      S_QOUT: begin
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/gcna_div.sv
`default_nettype none
// Restoring unsigned divider, one quotient bit a cycle.
module gcna_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 48
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [DenW:0]   r;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [DenW:0]   trial;

  assign trial = {r[DenW-1:0], q[NumW-1]};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CntW'(NumW);
        q   <= num;
        r   <= '0;
        d   <= den;
      end else if (run) begin
        if (trial >= {1'b0, d}) begin
          r <= trial - {1'b0, d};
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          r <= trial;
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/gcna_norm.sv
`default_nettype none
// Scale a sum vector to unit length: normalize, square, root, three divides.
module gcna_norm (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [31:0] sx,
  input  wire logic signed [31:0] sy,
  input  wire logic signed [31:0] sz,
  output logic                    done,
  output logic signed [15:0]      ux,
  output logic signed [15:0]      uy,
  output logic signed [15:0]      uz
);

  typedef enum logic [7:0] {
    N_IDLE = 8'b00000001,
    N_SHL  = 8'b00000010,
    N_SQ   = 8'b00000100,
    N_SUM  = 8'b00001000,
    N_SQRT = 8'b00010000,
    N_DGO  = 8'b00100000,
    N_DWT  = 8'b01000000,
    N_FIN  = 8'b10000000
  } nst_t;

  nst_t        st;
  logic [32:0] m [3];
  logic [2:0]  neg;
  logic [32:0] top;
  logic [61:0] sq [3];
  logic [63:0] qv;
  logic [31:0] root;
  logic [63:0] rem;
  logic [4:0]  scnt;
  logic [1:0]  lane;
  logic        dgo, ddone;
  logic [63:0] dnum, dquo;
  logic [15:0] u [3];
  logic [14:0] uq;

  assign top   = (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                               : ((m[1] > m[2]) ? m[1] : m[2]);
  assign dnum  = ({31'd0, m[lane]} << 14) + 64'(root >> 1);

  gcna_div #(.NumW(64), .DenW(32)) u_div (
    .clk (clk), .rst (rst), .go (dgo), .num (dnum), .den (root),
    .done(ddone), .quo (dquo)
  );

  // One root digit a cycle: radicand bits 2 at a time.
  logic [33:0] rr;
  logic [33:0] tt;
  assign rr = {rem[31:0], qv[63:62]};
  assign tt = {root, 2'b01};
  assign uq = (dquo > 64'd16384) ? 15'd16384 : dquo[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= N_IDLE;
      done <= 1'b0;
      dgo  <= 1'b0;
    end else begin
      done <= 1'b0;
      dgo  <= 1'b0;
      unique case (st)
        N_IDLE: if (go) begin
          m[0] <= sx[31] ? 33'(-{sx[31], sx}) : {1'b0, sx};
          m[1] <= sy[31] ? 33'(-{sy[31], sy}) : {1'b0, sy};
          m[2] <= sz[31] ? 33'(-{sz[31], sz}) : {1'b0, sz};
          neg  <= {sz[31], sy[31], sx[31]};
          st   <= N_SHL;
        end
        N_SHL: begin
          if (top == 33'd0) begin
            u[0] <= '0; u[1] <= '0; u[2] <= '0;
            st <= N_FIN;
          end else if (top < 33'(1) << 29) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else if (top >= 33'(1) << 30) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else begin
            st <= N_SQ;
          end
        end
        N_SQ: begin
          for (int i = 0; i < 3; i++) sq[i] <= m[i][30:0] * m[i][30:0];
          st <= N_SUM;
        end
        N_SUM: begin
          qv   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
          rem  <= '0;
          root <= '0;
          scnt <= 5'd31;
          st   <= N_SQRT;
        end
        N_SQRT: begin
          if (rr >= tt) begin
            rem  <= 64'(rr - tt);
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= 64'(rr);
            root <= {root[30:0], 1'b0};
          end
          qv   <= qv << 2;
          scnt <= scnt - 1'b1;
          if (scnt == 5'd0) begin
            lane <= 2'd0;
            st   <= N_DGO;
          end
        end
        N_DGO: begin
          dgo <= 1'b1;
          st  <= N_DWT;
        end
        N_DWT: if (ddone) begin
          u[lane] <= neg[lane] ? 16'(-{1'b0, uq}) : {1'b0, uq};
          if (lane == 2'd2) st <= N_FIN;
          else begin
            lane <= lane + 1'b1;
            st   <= N_DGO;
          end
        end
        N_FIN: begin
          done <= 1'b1;
          st   <= N_IDLE;
        end
        default: st <= N_IDLE;
      endcase
    end
  end

  assign ux = u[0];
  assign uy = u[1];
  assign uz = u[2];

endmodule
`default_nettype wire

FILE: rtl/core/gcna_dp.sv
`default_nettype none
module gcna_dp #(
  parameter int unsigned GridDim       = 100,
  parameter int unsigned CellsPerMeter = 50,
  parameter int unsigned CountWidth    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gcna_pkg::ctl_t    ctl,
  input  wire gcna_pkg::item_t   item,
  output gcna_pkg::sts_t         sts,
  output logic                   strobe,
  output gcna_pkg::result_t      result
);

  localparam int unsigned Cells = GridDim * GridDim;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned IdxW  = $clog2(GridDim);
  localparam int unsigned EntW  = 4 * 32 + CountWidth;
  localparam logic [CountWidth-1:0] CntMax = '1;

  logic [EntW-1:0]  mem [Cells];
  logic [EntW-1:0]  rdata;
  logic [AddrW-1:0] addr, caddr;
  logic             on_grid;
  logic signed [15:0] z, nx, ny, nz;
  logic             div_done, nrm_done;

  // Cell index from a Q2.14 coordinate.
  function automatic logic [IdxW:0] gidx(input logic signed [15:0] c);
    logic signed [47:0] t;
    logic signed [47:0] i;
    t = 48'(c) * 48'(CellsPerMeter) + 48'(GridDim) * 48'sd8192;
    i = t >>> 14;
    if (t < 0 || i >= 48'(GridDim)) gidx = {1'b1, IdxW'(0)};
    else gidx = {1'b0, i[IdxW-1:0]};
  endfunction

  logic [IdxW:0] gc, gr;
  assign gc = gidx(item.point_x);
  assign gr = gidx(item.point_y);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      z <= item.point_z; nx <= item.surface_nx;
      ny <= item.surface_ny; nz <= item.surface_nz;
      if (gcna_pkg::cmd_t'(item.command) == gcna_pkg::CMD_QUERY) begin
        on_grid <= 32'(item.cell_col) < GridDim && 32'(item.cell_row) < GridDim;
        addr    <= AddrW'(32'(item.cell_col) * GridDim + 32'(item.cell_row));
      end else begin
        on_grid <= !gc[IdxW] && !gr[IdxW];
        addr    <= AddrW'(32'(gc[IdxW-1:0]) * GridDim + 32'(gr[IdxW-1:0]));
      end
    end
  end

  // Clear sweep counter.
  always_ff @(posedge clk) begin
    if (rst || !ctl.clr_step) caddr <= '0;
    else caddr <= caddr + 1'b1;
  end
  assign sts = '{clr_last: caddr == AddrW'(Cells - 1), on_grid: on_grid,
                 div_done: div_done, nrm_done: nrm_done};

  function automatic logic [31:0] sadd(input logic [31:0] a, input logic signed [15:0] b);
    logic signed [32:0] s;
    s = 33'(signed'(a)) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) sadd = 32'h7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) sadd = 32'h8000_0000;
    else sadd = s[31:0];
  endfunction

  logic [EntW-1:0] wdata;
  logic [CountWidth-1:0] rc;
  assign rc = rdata[CountWidth-1:0];

  always_ff @(posedge clk) begin
    if (ctl.rd) rdata <= mem[addr];
    else if (ctl.clr_step) mem[caddr] <= '0;
    else if (ctl.wr && rc != CntMax) mem[addr] <= wdata;
  end

  // Register the modified entry in the modify state, ahead of its write.
  always_ff @(posedge clk) begin
    wdata <= {sadd(rdata[EntW-1 -: 32], z), sadd(rdata[EntW-33 -: 32], nx),
              sadd(rdata[EntW-65 -: 32], ny), sadd(rdata[EntW-97 -: 32], nz),
              rc + 1'b1};
  end

  // Query: height mean through the divider.
  logic signed [31:0] hs;
  logic [63:0] hnum, hquo;
  logic        occ;
  assign hs   = rdata[EntW-1 -: 32];
  assign occ  = on_grid && rc != '0;
  assign hnum = 64'(hs[31] ? 33'(-{hs[31], hs}) : {1'b0, hs}) + 64'(rc >> 1);

  gcna_div #(.NumW(64), .DenW(CountWidth)) u_hdiv (
    .clk(clk), .rst(rst), .go(ctl.div_start), .num(hnum), .den(rc),
    .done(div_done), .quo(hquo)
  );

  logic signed [15:0] ux, uy, uz;
  gcna_norm u_norm (
    .clk(clk), .rst(rst), .go(ctl.nrm_start),
    .sx(rdata[EntW-33 -: 32]), .sy(rdata[EntW-65 -: 32]), .sz(rdata[EntW-97 -: 32]),
    .done(nrm_done), .ux(ux), .uy(uy), .uz(uz)
  );

  logic signed [15:0] mh;
  always_comb begin
    if (!hs[31]) mh = (hquo > 64'd32767) ? 16'sd32767 : 16'(hquo);
    else mh = (hquo > 64'd32768) ? -16'sd32768 : 16'(-hquo);
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= ctl.emit;
    if (ctl.emit) begin
      result.cell_occupied <= occ;
      result.mean_height   <= occ ? mh : '0;
      result.unit_nx       <= occ ? ux : '0;
      result.unit_ny       <= occ ? uy : '0;
      result.unit_nz       <= occ ? uz : '0;
      result.point_total   <= !occ ? '0 :
        (32'(rc) > 32'd65535) ? 16'hFFFF : 16'(rc);
    end
  end

endmodule
`default_nettype wire
